@@ src/nec_ir_interval_decoder_assert.svh @@
// Assertion macros for the NEC infrared interval decoder.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef NEC_IR_INTERVAL_DECODER_ASSERT_SVH
`define NEC_IR_INTERVAL_DECODER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define NID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define NID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/nid_pkg.sv @@
// Shared types, register codes and reset values of the NEC interval decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package nid_pkg;

  localparam int NID_FRAME_BYTES = 16;

  // Configuration register file
  localparam int NID_REG_W     = 16;
  localparam int NID_REG_IDX_W = 3;

  localparam logic [NID_REG_IDX_W-1:0] REG_HDR_MIN  = 3'd0;
  localparam logic [NID_REG_IDX_W-1:0] REG_HDR_MAX  = 3'd1;
  localparam logic [NID_REG_IDX_W-1:0] REG_ZERO_MIN = 3'd2;
  localparam logic [NID_REG_IDX_W-1:0] REG_ZERO_MAX = 3'd3;
  localparam logic [NID_REG_IDX_W-1:0] REG_ONE_MIN  = 3'd4;
  localparam logic [NID_REG_IDX_W-1:0] REG_ONE_MAX  = 3'd5;
  localparam logic [NID_REG_IDX_W-1:0] REG_GAP_MIN  = 3'd6;
  localparam logic [NID_REG_IDX_W-1:0] REG_GAP_MAX  = 3'd7;

  localparam logic [NID_REG_W-1:0] RST_HDR_MIN  = 16'd5000;
  localparam logic [NID_REG_W-1:0] RST_HDR_MAX  = 16'd14000;
  localparam logic [NID_REG_W-1:0] RST_ZERO_MIN = 16'd900;
  localparam logic [NID_REG_W-1:0] RST_ZERO_MAX = 16'd1300;
  localparam logic [NID_REG_W-1:0] RST_ONE_MIN  = 16'd2000;
  localparam logic [NID_REG_W-1:0] RST_ONE_MAX  = 16'd2500;
  localparam logic [NID_REG_W-1:0] RST_GAP_MIN  = 16'd8000;
  localparam logic [NID_REG_W-1:0] RST_GAP_MAX  = 16'd9000;

  // Interval class as seen inside a frame, in priority order
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_ZERO  = 2'd0;
  localparam cls_t CLS_ONE   = 2'd1;
  localparam cls_t CLS_GAP   = 2'd2;
  localparam cls_t CLS_OTHER = 2'd3;

  // Classified beat handed from front to back
  typedef struct packed {
    logic hdr_hit;
    cls_t cls;
  } nid_item_t;

  // Queue between front and back
  localparam int NID_QDEPTH = 2;
  localparam int NID_QPTR_W = (NID_QDEPTH > 1) ? $clog2(NID_QDEPTH) : 1;
  localparam int NID_QCNT_W = $clog2(NID_QDEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } nid_qstat_t;

  // Exclusive window test: lo < v < hi
  function automatic logic in_window(logic [NID_REG_W-1:0] v,
                                     logic [NID_REG_W-1:0] lo,
                                     logic [NID_REG_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

endpackage

@@ src/nid_front.sv @@
// Front end: window registers and interval classification.
// Depends on nid_pkg.
`timescale 1ns / 1ps

module nid_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [nid_pkg::NID_REG_IDX_W-1:0] cfg_index,
  input  logic [nid_pkg::NID_REG_W-1:0]   cfg_wdata,
  input  logic [nid_pkg::NID_REG_W-1:0]   interval_us,
  output nid_pkg::nid_item_t              item
);
  import nid_pkg::*;

  logic [NID_REG_W-1:0] hdr_min_r, hdr_max_r;
  logic [NID_REG_W-1:0] zero_min_r, zero_max_r;
  logic [NID_REG_W-1:0] one_min_r, one_max_r;
  logic [NID_REG_W-1:0] gap_min_r, gap_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_min_r  <= RST_HDR_MIN;
      hdr_max_r  <= RST_HDR_MAX;
      zero_min_r <= RST_ZERO_MIN;
      zero_max_r <= RST_ZERO_MAX;
      one_min_r  <= RST_ONE_MIN;
      one_max_r  <= RST_ONE_MAX;
      gap_min_r  <= RST_GAP_MIN;
      gap_max_r  <= RST_GAP_MAX;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HDR_MIN:  hdr_min_r  <= cfg_wdata;
        REG_HDR_MAX:  hdr_max_r  <= cfg_wdata;
        REG_ZERO_MIN: zero_min_r <= cfg_wdata;
        REG_ZERO_MAX: zero_max_r <= cfg_wdata;
        REG_ONE_MIN:  one_min_r  <= cfg_wdata;
        REG_ONE_MAX:  one_max_r  <= cfg_wdata;
        REG_GAP_MIN:  gap_min_r  <= cfg_wdata;
        REG_GAP_MAX:  gap_max_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Zero window wins over one, one wins over gap
  always_comb begin
    item.hdr_hit = in_window(interval_us, hdr_min_r, hdr_max_r);
    if (in_window(interval_us, zero_min_r, zero_max_r)) begin
      item.cls = CLS_ZERO;
    end else if (in_window(interval_us, one_min_r, one_max_r)) begin
      item.cls = CLS_ONE;
    end else if (in_window(interval_us, gap_min_r, gap_max_r)) begin
      item.cls = CLS_GAP;
    end else begin
      item.cls = CLS_OTHER;
    end
  end

endmodule

@@ src/nid_queue.sv @@
// Short FIFO of classified beats between front and back.
// Depends on nid_pkg.
`timescale 1ns / 1ps

module nid_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nid_pkg::nid_item_t  push_item,
  input  logic                pop,
  output nid_pkg::nid_item_t  head_item,
  output nid_pkg::nid_qstat_t qstat
);
  import nid_pkg::*;

  localparam logic [NID_QPTR_W-1:0] PTR_LAST = NID_QPTR_W'(NID_QDEPTH - 1);
  localparam logic [NID_QCNT_W-1:0] CNT_FULL = NID_QCNT_W'(NID_QDEPTH);

  nid_item_t               mem_r [NID_QDEPTH];
  logic [NID_QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [NID_QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NID_QCNT_W-1:0]   count_r, count_nxt;

  assign qstat.full  = (count_r == CNT_FULL);
  assign qstat.empty = (count_r == '0);
  assign head_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ src/nid_back.sv @@
// Back end: frame state, byte assembly and the registered result beat.
// Depends on nid_pkg.
`timescale 1ns / 1ps

module nid_back #(
  parameter int FRAME_BYTES = nid_pkg::NID_FRAME_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nid_pkg::nid_item_t head_item,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_byte_valid,
  output logic [7:0]         out_byte_value,
  output logic [3:0]         out_byte_index,
  output logic               out_frame_complete,
  output logic               out_header_accepted,
  output logic               out_gap_seen,
  output logic               out_frame_aborted,
  output logic               out_in_frame
);
  import nid_pkg::*;

  localparam int POS_W = $clog2(FRAME_BYTES + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]       bit_cnt_r, bit_cnt_nxt;
  logic [7:0]       shift_r, shift_nxt;

  logic             out_valid_r;
  logic             byte_valid_r, byte_valid_nxt;
  logic [7:0]       byte_value_r, byte_value_nxt;
  logic [3:0]       byte_index_r, byte_index_nxt;
  logic             done_r, done_nxt;
  logic             hdr_r, hdr_nxt;
  logic             gap_r, gap_nxt;
  logic             abort_r, abort_nxt;
  logic             in_frame_r;

  logic [7:0]       shift_in;
  logic [POS_W-1:0] pos_m1;
  logic [POS_W+3:0] pos_m1_ext;

  // Take the head beat when the output register is empty or drains now
  assign pop = head_valid && (!out_valid_r || !out_stall);

  assign shift_in   = {(head_item.cls == CLS_ONE), shift_r[7:1]};
  assign pos_m1     = pos_r - 1'b1;
  assign pos_m1_ext = {4'b0000, pos_m1};

  always_comb begin
    pos_nxt        = pos_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    byte_valid_nxt = 1'b0;
    byte_value_nxt = '0;
    byte_index_nxt = '0;
    done_nxt       = 1'b0;
    hdr_nxt        = 1'b0;
    gap_nxt        = 1'b0;
    abort_nxt      = 1'b0;
    if (pos_r == '0) begin
      if (head_item.hdr_hit) begin
        pos_nxt     = POS_W'(1);
        bit_cnt_nxt = '0;
        shift_nxt   = '0;
        hdr_nxt     = 1'b1;
      end
    end else begin
      unique case (head_item.cls) inside
        CLS_ZERO, CLS_ONE: begin
          if (bit_cnt_r == 3'd7) begin
            byte_valid_nxt = 1'b1;
            byte_value_nxt = shift_in;
            byte_index_nxt = pos_m1_ext[3:0];
            bit_cnt_nxt    = '0;
            shift_nxt      = '0;
            if (pos_r == POS_LAST) begin
              pos_nxt  = '0;
              done_nxt = 1'b1;
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end else begin
            bit_cnt_nxt = bit_cnt_r + 1'b1;
            shift_nxt   = shift_in;
          end
        end
        CLS_GAP: begin
          bit_cnt_nxt = '0;
          gap_nxt     = 1'b1;
        end
        CLS_OTHER: begin
          pos_nxt   = '0;
          abort_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        pos_r       <= pos_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        shift_r     <= shift_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_valid_r <= byte_valid_nxt;
      byte_value_r <= byte_value_nxt;
      byte_index_r <= byte_index_nxt;
      done_r       <= done_nxt;
      hdr_r        <= hdr_nxt;
      gap_r        <= gap_nxt;
      abort_r      <= abort_nxt;
      in_frame_r   <= (pos_nxt != '0);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte_valid      = byte_valid_r;
  assign out_byte_value      = byte_value_r;
  assign out_byte_index      = byte_index_r;
  assign out_frame_complete  = done_r;
  assign out_header_accepted = hdr_r;
  assign out_gap_seen        = gap_r;
  assign out_frame_aborted   = abort_r;
  assign out_in_frame        = in_frame_r;

endmodule

@@ src/nec_ir_interval_decoder.sv @@
// Top level of the NEC infrared interval decoder: front, queue and back.
// Depends on nid_pkg, nid_front, nid_queue, nid_back and the assertion header.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_interval_us
//   out_     output     out_valid / out_stall byte and frame flags, one beat per input
//   cfg_     input      cfg_wr_en             cfg_index, cfg_wdata
//
// One input beat a cycle sustained while out_stall stays low; each result appears in
// the cycle after its beat is taken by the back end, set by the single frame-state
// update there. An accepted beat passes through the queue before the back end registers it.
// Reset (rst_n low, synchronous) loads the default windows and drops to idle.
// out_stall fills the two-entry queue; in_stall rises only when it is full.
`timescale 1ns / 1ps

module nec_ir_interval_decoder #(
  parameter int FRAME_BYTES = nid_pkg::NID_FRAME_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [nid_pkg::NID_REG_IDX_W-1:0] cfg_index,
  input  logic [nid_pkg::NID_REG_W-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       in_interval_us,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_byte_valid,
  output logic [7:0]                        out_byte_value,
  output logic [3:0]                        out_byte_index,
  output logic                              out_frame_complete,
  output logic                              out_header_accepted,
  output logic                              out_gap_seen,
  output logic                              out_frame_aborted,
  output logic                              out_in_frame
);
  import nid_pkg::*;

  nid_item_t  front_item;
  nid_item_t  head_item;
  nid_qstat_t qstat;
  logic       push;
  logic       pop;

  // Hold off the sender only when the queue has no room
  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  // Classify the interval against all windows as it arrives
  nid_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .interval_us (in_interval_us),
    .item        (front_item)
  );

  // Decouple classification from the frame state so each side stalls alone
  nid_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  // Advance the frame state and register one result beat per class beat
  nid_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_item           (head_item),
    .head_valid          (!qstat.empty),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte_valid      (out_byte_valid),
    .out_byte_value      (out_byte_value),
    .out_byte_index      (out_byte_index),
    .out_frame_complete  (out_frame_complete),
    .out_header_accepted (out_header_accepted),
    .out_gap_seen        (out_gap_seen),
    .out_frame_aborted   (out_frame_aborted),
    .out_in_frame        (out_in_frame)
  );

`include "nec_ir_interval_decoder_assert.svh"

  // A completed frame always carries its last byte and leaves the frame
`NID_ASSERT_NOW(a_done_last_byte, out_valid && out_frame_complete, out_byte_valid && !out_in_frame, "frame end without byte or still in frame")
  // A header opens a frame and never carries a byte
`NID_ASSERT_NOW(a_hdr_opens, out_valid && out_header_accepted, out_in_frame && !out_byte_valid && !out_gap_seen, "header beat malformed")
  // An abort leaves the frame and carries nothing else
`NID_ASSERT_NOW(a_abort_clean, out_valid && out_frame_aborted, !out_in_frame && !out_byte_valid && !out_gap_seen, "abort beat malformed")
  // A waiting class beat with a free output register shows up next cycle
`NID_ASSERT_NEXT(a_back_drains, !qstat.empty && !out_valid, out_valid, "back end failed to take a queued beat")

endmodule
